// File: sv/percent_encoder_defines.svh
`ifndef PERCENT_ENCODER_DEFINES_SVH
`define PERCENT_ENCODER_DEFINES_SVH

// same-cycle implication
`define PE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/pe_pkg.sv
package pe_pkg;

	typedef logic [7:0] byte_t;
	typedef logic [2:0] tbl_sel_t;
	typedef logic [1:0] phase_t;

	localparam tbl_sel_t TBL_URI       = 3'd0;
	localparam tbl_sel_t TBL_ARGS      = 3'd1;
	localparam tbl_sel_t TBL_COMPONENT = 3'd2;
	localparam tbl_sel_t TBL_HTML      = 3'd3;
	localparam tbl_sel_t TBL_REFRESH   = 3'd4;
	localparam tbl_sel_t TBL_MEMCACHED = 3'd5;

	localparam phase_t PH_PCT = 2'd0;
	localparam phase_t PH_HI  = 2'd1;
	localparam phase_t PH_LO  = 2'd2;

	localparam byte_t CHAR_PERCENT = 8'h25;
	localparam byte_t CHAR_ZERO    = 8'h30;
	localparam byte_t CHAR_A_LOW   = 8'h61;

	localparam logic [31:0] ESC_MAPS [0:5][0:7] = '{
		'{32'hffffffff, 32'h80000029, 32'h00000000, 32'h80000000,
		  32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff},
		'{32'hffffffff, 32'h88000869, 32'h00000000, 32'h80000000,
		  32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff},
		'{32'hffffffff, 32'hfc009fff, 32'h78000001, 32'hb8000001,
		  32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff},
		'{32'hffffffff, 32'h000000ad, 32'h00000000, 32'h80000000,
		  32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff},
		'{32'hffffffff, 32'h00000085, 32'h00000000, 32'h80000000,
		  32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff},
		'{32'hffffffff, 32'h00000021, 32'h00000000, 32'h00000000,
		  32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000}
	};

	// zero byte is never escaped; selectors past the last map use memcached
	function automatic logic needs_escape(tbl_sel_t sel, byte_t b);
		tbl_sel_t s;
		s = (sel > TBL_MEMCACHED) ? TBL_MEMCACHED : sel;
		return (b != 8'h00) && ESC_MAPS[s][b[7:5]][b[4:0]];
	endfunction

	function automatic byte_t hex_char(logic [3:0] n);
		return (n < 4'd10) ? (CHAR_ZERO + {4'd0, n}) : (CHAR_A_LOW + {4'd0, n} - 8'd10);
	endfunction

endpackage

// File: sv/percent_encoder.sv
// Channel  | Dir | tdata            | tuser       | tlast
// s_axis   | in  | [7:0] in_byte    | -           | in_last
// m_axis   | out | [7:0] out_byte   | [0] out_last| out_end
// cfg      | in  | [2:0] escape_table (write on cfg_we)
//
// One byte accepted per cycle while s_axis_tready is high; an escaped byte
// holds the output for three transfers, a plain byte or terminator for one.
// An input transfer passes through the input register, then the expansion
// register, before its first result reaches m_axis.
// Reset clears the terminated flag, the map select and both stage valids.
// A stalled m_axis backs up into the input register, then s_axis_tready falls.
`include "percent_encoder_defines.svh"

module percent_encoder
	import pe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [2:0] cfg_data,      // [2:0] escape_table
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] in_byte
	input  logic       s_axis_tlast,  // in_last
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] out_byte
	output logic       m_axis_tuser,  // [0] out_last
	output logic       m_axis_tlast   // out_end
);

	tbl_sel_t tbl_q;
	logic     term_q;

	logic     v_s1;
	byte_t    byte_s1;
	logic     last_s1;

	logic     v_s2;
	byte_t    byte_s2;
	logic     last_s2;
	logic     esc_s2;
	phase_t   phase_s2;

	logic     in_xfer;
	logic     out_xfer;
	logic     final_s2;
	logic     adv;
	logic     load_s1;

	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign out_xfer = m_axis_tvalid && m_axis_tready;
	assign final_s2 = !esc_s2 || (phase_s2 == PH_LO);
	assign adv      = !v_s2 || (out_xfer && final_s2);
	assign s_axis_tready = !v_s1 || adv;
	assign load_s1  = in_xfer && !term_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tbl_q <= TBL_URI;
		end else if (cfg_we) begin
			tbl_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_q <= 1'b0;
		end else if (in_xfer) begin
			if (term_q) begin
				term_q <= !s_axis_tlast;
			end else begin
				term_q <= (s_axis_tdata == 8'h00) && !s_axis_tlast;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			v_s1 <= load_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2     <= 1'b0;
			phase_s2 <= PH_PCT;
		end else if (adv) begin
			v_s2     <= v_s1;
			phase_s2 <= PH_PCT;
		end else if (out_xfer) begin
			phase_s2 <= phase_s2 + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			byte_s2 <= byte_s1;
			last_s2 <= last_s1;
			esc_s2  <= needs_escape(tbl_q, byte_s1);
		end
	end

	always_comb begin
		m_axis_tdata = byte_s2;
		m_axis_tuser = 1'b1;
		m_axis_tlast = last_s2 || (byte_s2 == 8'h00);
		if (esc_s2) begin
			case (phase_s2)
				PH_PCT: begin
					m_axis_tdata = CHAR_PERCENT;
					m_axis_tuser = 1'b0;
					m_axis_tlast = 1'b0;
				end
				PH_HI: begin
					m_axis_tdata = hex_char(byte_s2[7:4]);
					m_axis_tuser = 1'b0;
					m_axis_tlast = 1'b0;
				end
				default: begin
					m_axis_tdata = hex_char(byte_s2[3:0]);
					m_axis_tlast = last_s2;
				end
			endcase
		end
	end

	assign m_axis_tvalid = v_s2;

	`PE_ASSERT_NOW(a_plain_single, v_s2 && !esc_s2, phase_s2 == PH_PCT, "plain byte past first phase")
	`PE_ASSERT_NOW(a_phase_range, v_s2, phase_s2 != 2'd3, "phase out of range")
	`PE_ASSERT_NEXT(a_esc_continues, out_xfer && !final_s2, m_axis_tvalid, "escape sequence broken")
	`PE_ASSERT_NOW(a_end_is_last, m_axis_tvalid && m_axis_tlast, m_axis_tuser, "end without last")
	`PE_ASSERT_NEXT(a_s1_holds, v_s1 && !adv, v_s1 && $stable(byte_s1), "input stage lost")

endmodule
